// ----- hw/rtl/unordered_bag_table_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the unordered bag table
// Same-cycle and next-cycle implications on i_clk, masked while in reset.
// ---------------------------------------------------------------------------
`ifndef UNORDERED_BAG_TABLE_ASSERT_SVH
`define UNORDERED_BAG_TABLE_ASSERT_SVH

`define UBT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("unordered_bag_table: check failed");

`define UBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("unordered_bag_table: check failed");

`endif

// ----- hw/rtl/ubt_pkg.sv -----
// ---------------------------------------------------------------------------
// ubt_pkg
// Shared types and constants of the unordered bag table.
// ---------------------------------------------------------------------------
`default_nettype none

package ubt_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int VALUE_W      = 32;
    localparam int OUT_CNT_W    = 8;

    typedef enum logic [1:0] {
        MODE_INSERT    = 2'd0,
        MODE_ERASE_ONE = 2'd1,
        MODE_ERASE_ALL = 2'd2,
        MODE_CLEAR     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MOVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/ubt_mem.sv -----
// ---------------------------------------------------------------------------
// ubt_mem
// Entry store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module ubt_mem
    import ubt_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int AW    = 7
) (
    input  wire logic               i_clk,
    input  wire t_mem_ctl           i_ctl,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [VALUE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ubt_ctrl.sv -----
// ---------------------------------------------------------------------------
// ubt_ctrl
// Operation sequencer: insert, clear, and the read-compare-move erase scan.
// ---------------------------------------------------------------------------
`default_nettype none

module ubt_ctrl
    import ubt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int CNT_W    = 8,
    parameter int AW       = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_out_free,
    output logic                    o_done,
    output logic                    o_ok,
    output logic      [CNT_W-1:0]   o_count,
    output logic      [CNT_W-1:0]   o_removed,
    output t_mem_ctl                o_mem_ctl,
    output logic      [AW-1:0]      o_waddr,
    output logic      [VALUE_W-1:0] o_wdata,
    output logic      [AW-1:0]      o_raddr,
    input  wire logic [VALUE_W-1:0] i_rdata
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic               r_ok, n_ok;
    t_mode              r_mode, n_mode;
    logic [VALUE_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]   w_last;

    assign w_last = r_cnt - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_rem  <= n_rem;
        r_ok   <= n_ok;
        r_mode <= n_mode;
        r_key  <= n_key;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_rem     = r_rem;
        n_ok      = r_ok;
        n_mode    = r_mode;
        n_key     = r_key;
        o_ready   = 1'b0;
        o_done    = 1'b0;
        o_mem_ctl = '0;
        o_waddr   = r_idx[AW-1:0];
        o_wdata   = i_rdata;
        o_raddr   = r_idx[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_mode = t_mode'(i_mode);
                    n_key  = i_value;
                    n_idx  = '0;
                    n_rem  = '0;
                    n_ok   = 1'b0;
                    unique case (t_mode'(i_mode))
                        MODE_INSERT: begin
                            o_waddr = r_cnt[AW-1:0];
                            o_wdata = i_value;
                            if (r_cnt < CNT_W'(CAPACITY)) begin
                                o_mem_ctl.wr_en = 1'b1;
                                n_cnt = r_cnt + CNT_W'(1);
                                n_ok  = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        MODE_ERASE_ONE, MODE_ERASE_ALL: begin
                            n_state = ST_READ;
                        end
                        MODE_CLEAR: begin
                            n_rem   = r_cnt;
                            n_cnt   = '0;
                            n_ok    = 1'b1;
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                if (r_idx < r_cnt) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CMP: begin
                if (i_rdata == r_key) begin
                    o_raddr = w_last[AW-1:0];
                    o_mem_ctl.rd_en = 1'b1;
                    n_state = ST_MOVE;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_READ;
                end
            end
            ST_MOVE: begin
                // last entry fills the hole; recheck the same slot
                o_mem_ctl.wr_en = 1'b1;
                n_cnt = w_last;
                n_rem = r_rem + CNT_W'(1);
                n_ok  = 1'b1;
                n_state = (r_mode == MODE_ERASE_ONE) ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ok      = r_ok;
    assign o_count   = r_cnt;
    assign o_removed = r_rem;

endmodule

`default_nettype wire

// ----- hw/rtl/unordered_bag_table.sv -----
// Insert and clear: the input beat moves the sequencer to ST_DONE; the result beat registers
// from there once the output slot is free, so it can stall on i_m_axis_tready.
// Erase: each entry is read (ST_READ) and compared (ST_CMP); a match is filled by the last entry
// (ST_MOVE). The scan ends via ST_DONE; an erase-one that removes goes from ST_MOVE to ST_DONE.
// One item in flight; the next input beat is taken the cycle after the result registers.
// Synchronous active-low reset empties the table; stored words need no clearing.
// ---------------------------------------------------------------------------
// unordered_bag_table
// Fixed-capacity unordered multiset of 32-bit values held in one memory.
// ---------------------------------------------------------------------------
`default_nettype none
`include "unordered_bag_table_assert.svh"

module unordered_bag_table
    import ubt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // value[31:0]
    input  wire logic [1:0]  i_s_axis_tuser,   // mode[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata    // ok[0], count[8:1], removed[16:9], zeros
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_mem_ctl             w_mem_ctl;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [VALUE_W-1:0]   w_wdata, w_rdata;
    logic                 w_done, w_ok, w_out_free;
    logic [CNT_W-1:0]     w_count, w_removed;
    logic [CNT_W+7:0]     w_cnt_ext, w_rem_ext;

    logic                 r_valid;
    logic                 r_ok;
    logic [OUT_CNT_W-1:0] r_count, r_removed;

    assign w_out_free = !r_valid || i_m_axis_tready;
    assign w_cnt_ext  = {8'b0, w_count};
    assign w_rem_ext  = {8'b0, w_removed};

    ubt_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .AW       (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_mode     (i_s_axis_tuser),
        .i_value    (i_s_axis_tdata),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_ok       (w_ok),
        .o_count    (w_count),
        .o_removed  (w_removed),
        .o_mem_ctl  (w_mem_ctl),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    ubt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_done) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_ok      <= w_ok;
            r_count   <= w_cnt_ext[7:0];
            r_removed <= w_rem_ext[7:0];
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {7'b0, r_removed, r_count, r_ok};

    `UBT_ASSERT_SAME(a_count_bound, 1'b1, w_count <= CNT_W'(CAPACITY))
    `UBT_ASSERT_NEXT(a_insert_grows,
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_INSERT
        && w_count < CNT_W'(CAPACITY), w_count == $past(w_count) + CNT_W'(1))
    `UBT_ASSERT_NEXT(a_clear_empties,
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_CLEAR, w_count == '0)
    `UBT_ASSERT_SAME(a_done_slot_free, w_done, !r_valid || i_m_axis_tready)

endmodule

`default_nettype wire
